### rtl/bdhe_pkg.sv
// Shared types and constants for the button debouncer with hold events.
package bdhe_pkg;

   localparam int NUM_BUTTONS_DEFAULT = 3;
   localparam int PIN_COUNT           = 3;
   localparam int DEBOUNCE_W          = 8;
   localparam int HOLD_W              = 16;
   localparam int ENABLE_W            = 3;
   localparam int INDEX_W             = 2;
   localparam int CSR_ADDR_W          = 4;
   localparam int CSR_DATA_W          = 32;
   localparam int REQ_DATA_W          = 8;
   localparam int RSP_DATA_W          = 8;

   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 8'd5;
   localparam logic [HOLD_W-1:0]     HOLD_RESET     = 16'd100;
   localparam logic [ENABLE_W-1:0]   ENABLE_RESET   = 3'd4;

   typedef enum logic [1:0] {
      REG_DEBOUNCE = 2'd0,
      REG_HOLD     = 2'd1,
      REG_ENABLE   = 2'd2,
      REG_UNUSED   = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      EV_NONE     = 3'd0,
      EV_PRESSED  = 3'd1,
      EV_SHORT    = 3'd2,
      EV_RELEASED = 3'd3,
      EV_LONG     = 3'd4
   } event_type;

   typedef struct packed {
      logic tick;
      logic clear;
      logic now;
      logic long_en;
   } cell_ctrl_type;

endpackage

### rtl/bdhe_button.sv
// Per-button debounce counter, hold timer and pending event latch.
module bdhe_button (
   input  logic                                  clock,
   input  logic                                  reset,
   input  bdhe_pkg::cell_ctrl_type               ctrl,
   input  logic [bdhe_pkg::DEBOUNCE_W-1:0]       stable_limit,
   input  logic [bdhe_pkg::HOLD_W-1:0]           hold_ticks,
   output logic                                  level_next,
   output bdhe_pkg::event_type                   pending
);

   logic                              raw_ff, raw_in;
   logic [bdhe_pkg::DEBOUNCE_W-1:0]   stable_ff, stable_in;
   logic                              level_ff, level_in;
   logic                              prev_ff, prev_in;
   logic [bdhe_pkg::HOLD_W-1:0]       hold_ff, hold_in;
   logic                              long_ff, long_in;
   bdhe_pkg::event_type               pend_ff, pend_in;

   logic [bdhe_pkg::HOLD_W-1:0]       hold_mid;
   logic                              long_mid;
   bdhe_pkg::event_type               pend_mid;
   logic [bdhe_pkg::DEBOUNCE_W-1:0]   stable_upd;
   logic                              level_upd;

   always_comb begin
      if (ctrl.now == raw_ff) begin
         stable_upd = (stable_ff < stable_limit) ? stable_ff + 1'b1 : stable_ff;
      end else begin
         stable_upd = '0;
      end
      level_upd = (stable_upd >= stable_limit) ? ctrl.now : level_ff;

      hold_mid = hold_ff;
      long_mid = long_ff;
      pend_mid = pend_ff;
      if (level_upd != prev_ff) begin
         if (level_upd) begin
            pend_mid = bdhe_pkg::EV_PRESSED;
            hold_mid = '0;
            long_mid = 1'b0;
         end else begin
            pend_mid = long_ff ? bdhe_pkg::EV_RELEASED : bdhe_pkg::EV_SHORT;
         end
      end

      raw_in    = raw_ff;
      stable_in = stable_ff;
      level_in  = level_ff;
      prev_in   = prev_ff;
      hold_in   = hold_ff;
      long_in   = long_ff;
      pend_in   = pend_ff;

      if (ctrl.tick) begin
         raw_in    = ctrl.now;
         stable_in = stable_upd;
         level_in  = level_upd;
         prev_in   = level_upd;
         hold_in   = hold_mid;
         long_in   = long_mid;
         pend_in   = pend_mid;
         if (level_upd) begin
            if (hold_mid < hold_ticks) begin
               hold_in = hold_mid + 1'b1;
            end
            if (ctrl.long_en && (hold_in >= hold_ticks) && !long_mid) begin
               pend_in = bdhe_pkg::EV_LONG;
               long_in = 1'b1;
            end
         end
      end else if (ctrl.clear) begin
         pend_in = bdhe_pkg::EV_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_ff    <= 1'b0;
         stable_ff <= '0;
         level_ff  <= 1'b0;
         prev_ff   <= 1'b0;
         hold_ff   <= '0;
         long_ff   <= 1'b0;
         pend_ff   <= bdhe_pkg::EV_NONE;
      end else begin
         raw_ff    <= raw_in;
         stable_ff <= stable_in;
         level_ff  <= level_in;
         prev_ff   <= prev_in;
         hold_ff   <= hold_in;
         long_ff   <= long_in;
         pend_ff   <= pend_in;
      end
   end

   assign level_next = level_in;
   assign pending    = pend_ff;

endmodule

### rtl/button_debounce_hold_events.sv
// Top level of the button debouncer with press, release and long-hold events.
// An accepted word is held in the input register and then moved to the result
// register. Throughput: one word per cycle unless the response side stalls;
// the per-button update is a single pass between the input and result registers.
// Reset clears all button state, the pipeline valids and restores the register
// defaults; no clearing pass is needed.
module button_debounce_hold_events #(
   parameter int NUM_BUTTONS = bdhe_pkg::NUM_BUTTONS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [2:0] pin_levels, [4:3] button_index, [7:5] zero
   input  logic [bdhe_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [0] action
   input  logic [0:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [2:0] event_code, [5:3] pressed_bits, [6] bad_index, [7] zero
   output logic [bdhe_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [bdhe_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [bdhe_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [bdhe_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   logic [bdhe_pkg::DEBOUNCE_W-1:0] debounce_ff, debounce_in;
   logic [bdhe_pkg::HOLD_W-1:0]     hold_ff, hold_in;
   logic [bdhe_pkg::ENABLE_W-1:0]   enable_ff, enable_in;
   bdhe_pkg::reg_index_type         csr_index;
   logic                            csr_write;

   logic                            s1_valid_ff, s1_valid_in;
   logic                            s1_action_ff;
   logic [bdhe_pkg::PIN_COUNT-1:0]  s1_pins_ff;
   logic [bdhe_pkg::INDEX_W-1:0]    s1_index_ff;

   logic                            out_valid_ff, out_valid_in;
   bdhe_pkg::event_type             out_event_ff, out_event_in;
   logic [bdhe_pkg::PIN_COUNT-1:0]  out_pressed_ff, out_pressed_in;
   logic                            out_bad_ff, out_bad_in;

   logic                            advance;
   logic                            req_take;
   logic                            do_tick;
   logic                            do_read;
   logic                            bad_index;

   bdhe_pkg::cell_ctrl_type         cell_ctrl  [NUM_BUTTONS];
   logic [NUM_BUTTONS-1:0]          cell_level;
   bdhe_pkg::event_type             cell_pend  [NUM_BUTTONS];

   assign csr_pready = 1'b1;
   assign csr_index  = bdhe_pkg::reg_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      debounce_in = debounce_ff;
      hold_in     = hold_ff;
      enable_in   = enable_ff;
      if (csr_write) begin
         case (csr_index)
            bdhe_pkg::REG_DEBOUNCE: debounce_in = csr_pwdata[bdhe_pkg::DEBOUNCE_W-1:0];
            bdhe_pkg::REG_HOLD:     hold_in     = csr_pwdata[bdhe_pkg::HOLD_W-1:0];
            bdhe_pkg::REG_ENABLE:   enable_in   = csr_pwdata[bdhe_pkg::ENABLE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         bdhe_pkg::REG_DEBOUNCE: csr_prdata = {24'd0, debounce_ff};
         bdhe_pkg::REG_HOLD:     csr_prdata = {16'd0, hold_ff};
         bdhe_pkg::REG_ENABLE:   csr_prdata = {29'd0, enable_ff};
         default:                csr_prdata = '0;
      endcase
   end

   assign advance    = s1_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~s1_valid_ff | advance;
   assign req_take   = req_tvalid & req_tready;
   assign do_tick    = advance & ~s1_action_ff;
   assign do_read    = advance & s1_action_ff;
   assign bad_index  = int'(s1_index_ff) >= NUM_BUTTONS;

   assign s1_valid_in  = req_take | (s1_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & ~rsp_tready);

   for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_button
      if (i < bdhe_pkg::PIN_COUNT) begin : g_pin
         assign cell_ctrl[i].now     = ~s1_pins_ff[i];
         assign cell_ctrl[i].long_en = enable_ff[i];
      end else begin : g_nopin
         assign cell_ctrl[i].now     = 1'b0;
         assign cell_ctrl[i].long_en = 1'b0;
      end
      assign cell_ctrl[i].tick  = do_tick;
      assign cell_ctrl[i].clear = do_read & (int'(s1_index_ff) == i);

      bdhe_button u_button (
         .clock          (clock),
         .reset          (reset),
         .ctrl           (cell_ctrl[i]),
         .stable_limit   (debounce_ff),
         .hold_ticks     (hold_ff),
         .level_next     (cell_level[i]),
         .pending        (cell_pend[i])
      );
   end

   for (genvar j = 0; j < bdhe_pkg::PIN_COUNT; j++) begin : g_pressed
      if (j < NUM_BUTTONS) begin : g_live
         assign out_pressed_in[j] = cell_level[j];
      end else begin : g_dead
         assign out_pressed_in[j] = 1'b0;
      end
   end

   always_comb begin
      out_event_in = bdhe_pkg::EV_NONE;
      if (s1_action_ff) begin
         for (int k = 0; k < NUM_BUTTONS; k++) begin
            if (int'(s1_index_ff) == k) begin
               out_event_in = cell_pend[k];
            end
         end
      end
      out_bad_in = s1_action_ff & bad_index;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff  <= bdhe_pkg::DEBOUNCE_RESET;
         hold_ff      <= bdhe_pkg::HOLD_RESET;
         enable_ff    <= bdhe_pkg::ENABLE_RESET;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         debounce_ff  <= debounce_in;
         hold_ff      <= hold_in;
         enable_ff    <= enable_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_action_ff <= req_tuser[0];
         s1_pins_ff   <= req_tdata[2:0];
         s1_index_ff  <= req_tdata[4:3];
      end
      if (advance) begin
         out_event_ff   <= out_event_in;
         out_pressed_ff <= out_pressed_in;
         out_bad_ff     <= out_bad_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_bad_ff, out_pressed_ff, out_event_ff};

endmodule

### tb/debounce_event_checker.sv
// Action codes and the checker that predicts and compares result words of the debouncer.
`timescale 1ns / 100ps

package button_check_pkg;

   typedef enum logic {
      ACT_TICK = 1'b0,
      ACT_READ = 1'b1
   } action_type;

endpackage

module debounce_event_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   // [2:0] pin_levels, [4:3] button_index, [7:5] zero
   input  logic [bdhe_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [0] action
   input  logic [0:0]                          req_tuser,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [2:0] event_code, [5:3] pressed_bits, [6] bad_index, [7] zero
   input  logic [bdhe_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic                                csr_pready,
   input  logic [bdhe_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [bdhe_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output int                                  mismatch_count,
   output int                                  words_due
);

   import bdhe_pkg::*;
   import button_check_pkg::*;

   localparam int BUTTONS = NUM_BUTTONS_DEFAULT;

   typedef struct {
      event_type  code;
      logic [2:0] pressed;
      logic       bad;
   } rsp_word_type;

   logic [DEBOUNCE_W-1:0] debounce_limit;
   logic [HOLD_W-1:0]     hold_limit;
   logic [ENABLE_W-1:0]   hold_enable;
   logic                  raw_lvl [BUTTONS];
   logic [DEBOUNCE_W-1:0] stable_cnt [BUTTONS];
   logic                  deb_lvl [BUTTONS];
   logic                  prev_lvl [BUTTONS];
   logic [HOLD_W-1:0]     hold_cnt [BUTTONS];
   logic                  long_seen [BUTTONS];
   event_type             latched_event [BUTTONS];
   rsp_word_type          rsp_words_due [$];
   int                    fail_tally = 0;
   int                    due_tally = 0;

   assign mismatch_count = fail_tally;
   assign words_due      = due_tally;

   function automatic void clear_buttons();
      debounce_limit = DEBOUNCE_RESET;
      hold_limit     = HOLD_RESET;
      hold_enable    = ENABLE_RESET;
      for (int i = 0; i < BUTTONS; i++) begin
         raw_lvl[i]       = 1'b0;
         stable_cnt[i]    = '0;
         deb_lvl[i]       = 1'b0;
         prev_lvl[i]      = 1'b0;
         hold_cnt[i]      = '0;
         long_seen[i]     = 1'b0;
         latched_event[i] = EV_NONE;
      end
   endfunction

   function automatic logic [2:0] debounced_bits();
      logic [2:0] bits;
      bits = '0;
      for (int i = 0; i < BUTTONS && i < PIN_COUNT; i++) begin
         bits[i] = deb_lvl[i];
      end
      return bits;
   endfunction

   function automatic void sample_pins(logic [2:0] pins);
      logic now;
      for (int i = 0; i < BUTTONS; i++) begin
         now = (i < PIN_COUNT) ? ~pins[i] : 1'b0;
         if (now == raw_lvl[i]) begin
            if (stable_cnt[i] < debounce_limit) begin
               stable_cnt[i] = stable_cnt[i] + 1'b1;
            end
         end else begin
            raw_lvl[i]    = now;
            stable_cnt[i] = '0;
         end
         if (stable_cnt[i] >= debounce_limit) begin
            deb_lvl[i] = raw_lvl[i];
         end
         if (deb_lvl[i] != prev_lvl[i]) begin
            if (deb_lvl[i]) begin
               latched_event[i] = EV_PRESSED;
               hold_cnt[i]      = '0;
               long_seen[i]     = 1'b0;
            end else begin
               latched_event[i] = long_seen[i] ? EV_RELEASED : EV_SHORT;
            end
            prev_lvl[i] = deb_lvl[i];
         end
         if (deb_lvl[i]) begin
            if (hold_cnt[i] < hold_limit) begin
               hold_cnt[i] = hold_cnt[i] + 1'b1;
            end
            if (i < PIN_COUNT && hold_enable[i] && hold_cnt[i] >= hold_limit &&
                !long_seen[i]) begin
               latched_event[i] = EV_LONG;
               long_seen[i]     = 1'b1;
            end
         end
      end
   endfunction

   function automatic rsp_word_type predict_rsp(action_type act, logic [2:0] pins,
                                                logic [1:0] idx);
      rsp_word_type w;
      w.code = EV_NONE;
      w.bad  = 1'b0;
      if (act == ACT_TICK) begin
         sample_pins(pins);
      end else if (idx >= BUTTONS) begin
         w.bad = 1'b1;
      end else begin
         w.code             = latched_event[idx];
         latched_event[idx] = EV_NONE;
      end
      w.pressed = debounced_bits();
      return w;
   endfunction

   function automatic void flag_field(string field, logic [2:0] expected,
                                      logic [2:0] actual);
      if (actual !== expected) begin
         fail_tally++;
         $display("%0t: %s expected %0d, got %0d", $time, field, expected, actual);
      end
   endfunction

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         clear_buttons();
         rsp_words_due.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[3:2]))
               REG_DEBOUNCE: debounce_limit = csr_pwdata[DEBOUNCE_W-1:0];
               REG_HOLD:     hold_limit     = csr_pwdata[HOLD_W-1:0];
               REG_ENABLE:   hold_enable    = csr_pwdata[ENABLE_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (rsp_words_due.size() == 0) begin
               fail_tally++;
               $display("%0t: result word %h arrived with none expected", $time, rsp_tdata);
            end else begin
               want = rsp_words_due.pop_front();
               flag_field("event_code", want.code, rsp_tdata[2:0]);
               flag_field("pressed_bits", want.pressed, rsp_tdata[5:3]);
               flag_field("bad_index", {2'b00, want.bad}, {2'b00, rsp_tdata[6]});
            end
         end
         if (req_tvalid && req_tready) begin
            rsp_words_due.push_back(predict_rsp(action_type'(req_tuser[0]), req_tdata[2:0],
                                                req_tdata[4:3]));
         end
      end
      due_tally = rsp_words_due.size();
   end

endmodule

### tb/tb.sv
// Testbench top for the button debouncer: stimulus, configuration, watchdog and verdict.
`timescale 1ns / 100ps

module tb;

   import bdhe_pkg::*;
   import button_check_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_STALL     = 300;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [0:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    mismatches;
   int                    words_due;

   int   send_idle_pct = 0;
   int   stall_pct = 0;
   logic want_long_stall = 1'b0;
   int   long_stall_left = 0;
   int   quiet_cycles = 0;
   int   cur_debounce = DEBOUNCE_RESET;
   int   cur_hold = HOLD_RESET;

   button_debounce_hold_events DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   debounce_event_checker event_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_pready     (csr_pready),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .mismatch_count (mismatches),
      .words_due      (words_due)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(negedge clock) begin
      if (want_long_stall) begin
         long_stall_left = LONG_STALL;
         want_long_stall = 1'b0;
      end
      if (long_stall_left > 0) begin
         long_stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic push_word(action_type act, logic [2:0] pins, logic [1:0] idx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {3'b000, idx, pins};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic settle_block();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (words_due != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(reg_index_type r, logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {r, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic apply_config(int debounce, int hold, int enable);
      settle_block();
      csr_write(REG_DEBOUNCE, debounce);
      csr_write(REG_HOLD, hold);
      csr_write(REG_ENABLE, enable);
      cur_debounce = debounce;
      cur_hold     = hold;
   endtask

   function automatic int pick_run();
      int span;
      span = (cur_hold < 60) ? cur_hold : 60;
      if ($urandom_range(99) < 60) begin
         return $urandom_range(0, cur_debounce + 3);
      end
      return $urandom_range(cur_debounce, cur_debounce + span + 6);
   endfunction

   // Pin levels are held for random runs around the thresholds, with single-tick glitches.
   task automatic run_phase(int count, int idle_pct, int stall, bit long_stall, bit mid_pause);
      logic [2:0] level;
      logic [2:0] pins;
      int         run_left [3];
      int         g;
      level = 3'b111;
      foreach (run_left[b]) run_left[b] = pick_run();
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      for (int n = 0; n < count; n++) begin
         if (long_stall && n == count / 3) want_long_stall = 1'b1;
         if (mid_pause && n == count / 2) settle_block();
         if ($urandom_range(99) < 25) begin
            push_word(ACT_READ, 3'($urandom), 2'($urandom));
         end else begin
            for (int b = 0; b < 3; b++) begin
               if (run_left[b] == 0) begin
                  level[b]    = ~level[b];
                  run_left[b] = pick_run();
               end else begin
                  run_left[b]--;
               end
            end
            pins = level;
            if ($urandom_range(99) < 8) begin
               g       = $urandom_range(2);
               pins[g] = ~pins[g];
            end
            push_word(ACT_TICK, pins, 2'($urandom));
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      push_word(ACT_READ, 3'b000, 2'd0);
      push_word(ACT_READ, 3'b000, 2'd3);
      repeat (6) push_word(ACT_TICK, 3'b000, 2'd0);
      push_word(ACT_READ, 3'b000, 2'd2);
      repeat (6) push_word(ACT_TICK, 3'b111, 2'd0);
      push_word(ACT_READ, 3'b000, 2'd2);
      push_word(ACT_READ, 3'b000, 2'd1);

      apply_config(0, 0, 7);
      push_word(ACT_TICK, 3'b010, 2'd0);
      push_word(ACT_READ, 3'b000, 2'd0);
      push_word(ACT_READ, 3'b000, 2'd1);
      push_word(ACT_TICK, 3'b111, 2'd0);
      push_word(ACT_READ, 3'b000, 2'd2);
      push_word(ACT_READ, 3'b000, 2'd0);

      apply_config(2, 10, 7);
      run_phase(220, 0, 0, 1'b1, 1'b0);
      apply_config(0, 5, 3);
      run_phase(200, 82, 0, 1'b0, 1'b1);
      apply_config(4, 0, 5);
      run_phase(200, 0, 82, 1'b0, 1'b0);
      apply_config(1, 20, 6);
      run_phase(200, 6, 6, 1'b0, 1'b0);
      apply_config($urandom_range(6), $urandom_range(30), $urandom_range(7));
      run_phase(120, 0, 0, 1'b0, 1'b0);
      apply_config(255, 65535, 0);
      run_phase(260, 6, 6, 1'b0, 1'b0);

      settle_block();
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
